>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the waveform feature extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/wfe_pkg.sv
// Shared constants, types and helpers of the waveform feature extractor.
package wfe_pkg;

   // Defaults of the top-level parameters
   localparam int NUM_THRESHOLDS_DEF = 5;
   localparam int MAX_WINDOW_DEF     = 32;
   localparam int MAX_SAMPLES_DEF    = 512;

   // Field widths
   localparam int SAMPLE_W   = 12;
   localparam int THR_W      = 16;
   localparam int LEN_CFG_W  = 6;
   localparam int CSR_DATA_W = 16;
   localparam int CNT_W      = 9;
   localparam int TIDX_W     = 3;
   localparam int PEAK_W     = 11;
   localparam int PWS_W      = 16;
   localparam int POS_W      = 9;
   localparam int ACC_W      = 26;

   localparam int LEN_RESET = 10;
   localparam int POS_MAX   = 511;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Register indexes
   localparam int REG_WINDOW_LENGTH = 0;
   localparam int REG_THRESHOLD_0   = 1;

   // Hysteresis states
   localparam logic [1:0] HY_NEITHER = 2'd0;
   localparam logic [1:0] HY_HIGH    = 2'd1;
   localparam logic [1:0] HY_LOW     = 2'd2;

   // Per-sample control handed to each threshold lane
   typedef struct packed {
      logic step;   // an item updates the state this cycle
      logic clear;  // the item is the last of the waveform
      logic full;   // the window holds window_length samples
   } lane_ctl_type;

   // Counters of one threshold lane
   typedef struct packed {
      logic [CNT_W-1:0] crossing;
      logic [CNT_W-1:0] above;
   } lane_cnt_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

endpackage

>>> rtl/wfe_if.sv
// Valid/ready channel interfaces for samples in and results out.
interface wfe_req_if import wfe_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       final_sample;

   modport source (output valid, output sample, output final_sample, input ready);
   modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface wfe_rsp_if import wfe_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [TIDX_W-1:0]          thresh_index;
   logic [CNT_W-1:0]           crossing_count;
   logic [CNT_W-1:0]           above_count;
   logic [PEAK_W-1:0]          peak_sample;
   logic signed [SAMPLE_W-1:0] trough_sample;
   logic [PWS_W-1:0]           peak_window_sum;
   logic [POS_W-1:0]           peak_position;
   logic signed [ACC_W-1:0]    window_sum_total;
   logic                       run_last;

   modport source (output valid, output thresh_index, output crossing_count,
                   output above_count, output peak_sample, output trough_sample,
                   output peak_window_sum, output peak_position,
                   output window_sum_total, output run_last, input ready);
   modport sink   (input valid, input thresh_index, input crossing_count,
                   input above_count, input peak_sample, input trough_sample,
                   input peak_window_sum, input peak_position,
                   input window_sum_total, input run_last, output ready);
endinterface

>>> rtl/wfe_thr_lane.sv
// One threshold lane: hysteresis crossing counter and above-threshold window counter.
module wfe_thr_lane import wfe_pkg::*; #(
   parameter int SUM_W = SAMPLE_W + 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lane_ctl_type               ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [SUM_W-1:0]    win_sum,
   input  logic [THR_W-1:0]           threshold,
   output lane_cnt_type               cnt_next
);

   localparam int HY_W  = THR_W + 2;
   localparam int CMP_W = (SUM_W > THR_W + 1) ? SUM_W : THR_W + 1;

   logic [1:0]               hy_ff;
   logic [1:0]               hy_in;
   lane_cnt_type             cnt_ff;
   logic                     cross_inc;
   logic signed [HY_W-1:0]   s_ext;
   logic signed [HY_W-1:0]   t_ext;
   logic signed [CMP_W-1:0]  win_ext;
   logic signed [CMP_W-1:0]  thr_cmp;
   logic                     hi;
   logic                     lo;
   logic                     above;

   // Compare the sample against +thr and -thr, the window sum against thr
   assign s_ext   = HY_W'(sample);
   assign t_ext   = HY_W'(threshold);
   assign win_ext = CMP_W'(win_sum);
   assign thr_cmp = CMP_W'(threshold);
   assign hi      = s_ext > t_ext;
   assign lo      = s_ext < -t_ext;
   assign above   = ctl.full && (win_ext > thr_cmp);

   // Advance the hysteresis state, flag a crossing on high/low swaps
   always_comb begin
      hy_in     = hy_ff;
      cross_inc = 1'b0;
      unique case (hy_ff)
         HY_NEITHER: begin
            if (hi) begin
               hy_in = HY_HIGH;
            end else if (lo) begin
               hy_in = HY_LOW;
            end
         end
         HY_HIGH: begin
            if (lo) begin
               hy_in     = HY_LOW;
               cross_inc = 1'b1;
            end
         end
         default: begin
            if (hi) begin
               hy_in     = HY_HIGH;
               cross_inc = 1'b1;
            end
         end
      endcase
   end

   assign cnt_next.crossing = cross_inc ? sat_inc(cnt_ff.crossing) : cnt_ff.crossing;
   assign cnt_next.above    = above ? sat_inc(cnt_ff.above) : cnt_ff.above;

   // Hold the lane state; drop it at the end of a waveform
   always_ff @(posedge clock) begin
      if (reset) begin
         hy_ff  <= HY_NEITHER;
         cnt_ff <= '0;
      end else if (ctl.step) begin
         if (ctl.clear) begin
            hy_ff  <= HY_NEITHER;
            cnt_ff <= '0;
         end else begin
            hy_ff  <= hy_in;
            cnt_ff <= cnt_next;
         end
      end
   end

endmodule

>>> rtl/waveform_feature_extractor.sv
// Top level of the waveform feature extractor: window sums, extremes, threshold lanes.
//
//   Channel  Direction  Handshake     Moves
//   req_bus  in         valid/ready   one item: sample, final_sample
//   rsp_bus  out        valid/ready   one item per threshold at waveform end
//   csr_*    in         write enable  window_length, threshold_0..N-1
//
// An item enters the input register and from there updates the running state
// (a row of partial sums, one per window length, plus extremes and lanes).
// A new item is taken every cycle while the input register is not held; the
// result register holds a finished waveform while the next one streams in. The
// last item of a waveform waits in the input register only while the previous
// waveform's results are still being drained.
// Synchronous reset clears the control and running state; no clearing pass is needed.
module waveform_feature_extractor import wfe_pkg::*; #(
   parameter int NUM_THRESHOLDS = NUM_THRESHOLDS_DEF,
   parameter int MAX_WINDOW     = MAX_WINDOW_DEF,
   parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   wfe_req_if.sink                               req_bus,
   wfe_rsp_if.source                             rsp_bus,
   input  logic                                  csr_write_en,
   input  logic [$clog2(NUM_THRESHOLDS+1)-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]                 csr_wdata
);

   localparam int CSR_IDX_W     = $clog2(NUM_THRESHOLDS + 1);
   localparam int LEN_W         = $clog2(MAX_WINDOW + 1);
   localparam int WIN_IDX_W     = $clog2(MAX_WINDOW);
   localparam int SUM_W         = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int IDX_W         = ($clog2(MAX_SAMPLES) + 1 > POS_W + 1) ?
                                  $clog2(MAX_SAMPLES) + 1 : POS_W + 1;
   localparam int LEN_RESET_EFF = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

   // Configuration registers
   logic [LEN_W-1:0]             len_ff;
   logic [LEN_W-1:0]             len_clamp;
   logic [LEN_CFG_W-1:0]         len_wr;
   logic [THR_W-1:0]             thr_ff [NUM_THRESHOLDS];

   // Input register
   logic                         in_valid_ff;
   logic signed [SAMPLE_W-1:0]   in_sample_ff;
   logic                         in_last_ff;
   logic                         advance;

   // Running state
   logic signed [SUM_W-1:0]      psum_ff [MAX_WINDOW];
   logic signed [SUM_W-1:0]      psum_in [MAX_WINDOW];
   logic [LEN_W-1:0]             len_m1;
   logic signed [SUM_W-1:0]      win_sum;
   logic [IDX_W-1:0]             idx_ff;
   logic [IDX_W-1:0]             idx_in;
   logic                         win_full;
   logic [POS_W-1:0]             pos_now;
   logic signed [SUM_W-1:0]      best_ff;
   logic signed [SUM_W-1:0]      best_in;
   logic [POS_W-1:0]             bpos_ff;
   logic [POS_W-1:0]             bpos_in;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   logic signed [ACC_W:0]        acc_sum;
   logic signed [SAMPLE_W-1:0]   max_ff;
   logic signed [SAMPLE_W-1:0]   max_in;
   logic signed [SAMPLE_W-1:0]   min_ff;
   logic signed [SAMPLE_W-1:0]   min_in;
   lane_ctl_type                 lane_ctl;
   lane_cnt_type                 lane_next [NUM_THRESHOLDS];

   // Result register
   logic                         snap_valid_ff;
   logic [TIDX_W-1:0]            out_idx_ff;
   lane_cnt_type                 snap_cnt_ff [NUM_THRESHOLDS];
   lane_cnt_type                 snap_sel;
   logic [PEAK_W-1:0]            snap_peak_ff;
   logic signed [SAMPLE_W-1:0]   snap_trough_ff;
   logic [PWS_W-1:0]             snap_pws_ff;
   logic [POS_W-1:0]             snap_pos_ff;
   logic signed [ACC_W-1:0]      snap_total_ff;
   logic                         rsp_fire;
   logic                         out_last;

   // Clamp the window length on write: zero becomes one, large values the maximum
   assign len_wr = csr_wdata[LEN_CFG_W-1:0];
   always_comb begin
      if (len_wr == '0) begin
         len_clamp = LEN_W'(1);
      end else if (int'(len_wr) > MAX_WINDOW) begin
         len_clamp = LEN_W'(MAX_WINDOW);
      end else begin
         len_clamp = LEN_W'(len_wr);
      end
   end

   // Take configuration writes; unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(LEN_RESET_EFF);
         for (int j = 0; j < NUM_THRESHOLDS; j++) begin
            thr_ff[j] <= '0;
         end
      end else if (csr_write_en) begin
         if (csr_index == CSR_IDX_W'(REG_WINDOW_LENGTH)) begin
            len_ff <= len_clamp;
         end
         for (int j = 0; j < NUM_THRESHOLDS; j++) begin
            if (csr_index == CSR_IDX_W'(REG_THRESHOLD_0 + j)) begin
               thr_ff[j] <= csr_wdata[THR_W-1:0];
            end
         end
      end
   end

   // Hold the last item of a waveform until the result register is free
   assign advance       = in_valid_ff && !(in_last_ff && snap_valid_ff);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_sample_ff <= req_bus.sample;
         in_last_ff   <= req_bus.final_sample;
      end
   end

   // Partial sums: entry k holds the sum of the newest k+1 samples
   always_comb begin
      psum_in[0] = SUM_W'(in_sample_ff);
      for (int k = 1; k < MAX_WINDOW; k++) begin
         psum_in[k] = psum_ff[k-1] + SUM_W'(in_sample_ff);
      end
   end

   assign len_m1  = len_ff - LEN_W'(1);
   assign win_sum = psum_in[len_m1[WIN_IDX_W-1:0]];

   // Window is full once window_length samples of this waveform are in
   assign win_full = idx_ff >= (IDX_W'(len_ff) - IDX_W'(1));
   assign idx_in   = (idx_ff == '1) ? idx_ff : idx_ff + 1'b1;
   assign pos_now  = (idx_ff < IDX_W'(POS_MAX)) ? idx_ff[POS_W-1:0] : POS_W'(POS_MAX);

   // Track the first peak window sum and its position
   always_comb begin
      best_in = best_ff;
      bpos_in = bpos_ff;
      if (win_full && (win_sum > best_ff)) begin
         best_in = win_sum;
         bpos_in = pos_now;
      end
   end

   // Accumulate full-window sums, saturating to the signed total range
   assign acc_sum = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(win_sum);
   always_comb begin
      acc_in = acc_ff;
      if (win_full) begin
         if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_in = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            acc_in = acc_sum[ACC_W-1:0];
         end
      end
   end

   assign max_in = (in_sample_ff > max_ff) ? in_sample_ff : max_ff;
   assign min_in = (in_sample_ff < min_ff) ? in_sample_ff : min_ff;

   // Update the running state; clear it after the last item of a waveform
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_WINDOW; k++) begin
            psum_ff[k] <= '0;
         end
         idx_ff  <= '0;
         best_ff <= '0;
         bpos_ff <= '0;
         acc_ff  <= '0;
         max_ff  <= '0;
         min_ff  <= '0;
      end else if (advance) begin
         if (in_last_ff) begin
            for (int k = 0; k < MAX_WINDOW; k++) begin
               psum_ff[k] <= '0;
            end
            idx_ff  <= '0;
            best_ff <= '0;
            bpos_ff <= '0;
            acc_ff  <= '0;
            max_ff  <= '0;
            min_ff  <= '0;
         end else begin
            psum_ff <= psum_in;
            idx_ff  <= idx_in;
            best_ff <= best_in;
            bpos_ff <= bpos_in;
            acc_ff  <= acc_in;
            max_ff  <= max_in;
            min_ff  <= min_in;
         end
      end
   end

   // Threshold lanes
   assign lane_ctl.step  = advance;
   assign lane_ctl.clear = in_last_ff;
   assign lane_ctl.full  = win_full;

   for (genvar j = 0; j < NUM_THRESHOLDS; j++) begin : g_lane
      wfe_thr_lane #(
         .SUM_W (SUM_W)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl),
         .sample    (in_sample_ff),
         .win_sum   (win_sum),
         .threshold (thr_ff[j]),
         .cnt_next  (lane_next[j])
      );
   end

   // Result register: load a finished waveform, step through the thresholds
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign out_last = out_idx_ff == TIDX_W'(NUM_THRESHOLDS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         out_idx_ff    <= '0;
      end else if (advance && in_last_ff) begin
         snap_valid_ff <= 1'b1;
         out_idx_ff    <= '0;
      end else if (rsp_fire) begin
         if (out_last) begin
            snap_valid_ff <= 1'b0;
         end else begin
            out_idx_ff <= out_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         snap_cnt_ff    <= lane_next;
         snap_peak_ff   <= max_in[PEAK_W-1:0];
         snap_trough_ff <= min_in;
         snap_pws_ff    <= PWS_W'(best_in);
         snap_pos_ff    <= bpos_in;
         snap_total_ff  <= acc_in;
      end
   end

   // Pick the counters of the threshold being reported
   always_comb begin
      snap_sel = '0;
      for (int j = 0; j < NUM_THRESHOLDS; j++) begin
         if (out_idx_ff == TIDX_W'(j)) begin
            snap_sel = snap_cnt_ff[j];
         end
      end
   end

   assign rsp_bus.valid            = snap_valid_ff;
   assign rsp_bus.thresh_index     = out_idx_ff;
   assign rsp_bus.crossing_count   = snap_sel.crossing;
   assign rsp_bus.above_count      = snap_sel.above;
   assign rsp_bus.peak_sample      = snap_peak_ff;
   assign rsp_bus.trough_sample    = snap_trough_ff;
   assign rsp_bus.peak_window_sum  = snap_pws_ff;
   assign rsp_bus.peak_position    = snap_pos_ff;
   assign rsp_bus.window_sum_total = snap_total_ff;
   assign rsp_bus.run_last         = out_last;

   // Checks
`include "assert_macros.svh"

   `ASSERT_NEXT(a_results_contiguous, clock, reset,
                rsp_fire && !out_last, snap_valid_ff)
   `ASSERT_NEXT(a_restart_index, clock, reset,
                rsp_fire && out_last, !snap_valid_ff || out_idx_ff == '0)
   `ASSERT_NEXT(a_clear_on_last, clock, reset,
                advance && in_last_ff, idx_ff == '0 && acc_ff == '0)
   `ASSERT_SAME(a_last_not_dropped, clock, reset,
                in_valid_ff && in_last_ff && snap_valid_ff, !req_bus.ready)

endmodule

>>> sim/tb_top.sv
// Self-checking testbench of the waveform feature extractor.
module tb_top;
   import wfe_pkg::*;

   localparam int NUM_THR      = NUM_THRESHOLDS_DEF;
   localparam int MAX_WIN      = MAX_WINDOW_DEF;
   localparam int CSR_IDX_W    = $clog2(NUM_THR + 1);
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int IDX_SAT      = 65535;
   localparam int ACC_HI       = 33554431;
   localparam int ACC_LO       = -33554432;

   typedef int thr_set_type [NUM_THR];
   typedef logic signed [SAMPLE_W-1:0] wave_type [$];

   // One result item of the block
   typedef struct {
      logic [TIDX_W-1:0]          thresh_index;
      logic [CNT_W-1:0]           crossing_count;
      logic [CNT_W-1:0]           above_count;
      logic [PEAK_W-1:0]          peak_sample;
      logic signed [SAMPLE_W-1:0] trough_sample;
      logic [PWS_W-1:0]           peak_window_sum;
      logic [POS_W-1:0]           peak_position;
      logic signed [ACC_W-1:0]    window_sum_total;
      logic                       run_last;
   } feature_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wfe_req_if req_bus ();
   wfe_rsp_if rsp_bus ();

   waveform_feature_extractor dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   feature_type pending_features [$];
   int          mismatch_count  = 0;
   bit          gaps_on         = 1'b1;
   int          rsp_hold_cycles = 0;

   // Register copies and running waveform state of the predictor
   int                         win_len;
   int                         thr_level [NUM_THR];
   logic signed [SAMPLE_W-1:0] history [MAX_WIN];
   int                         count_in_wave;
   int                         wave_max;
   int                         wave_min;
   int                         best_sum;
   int                         best_at;
   int                         sum_total;
   logic [1:0]                 hyst [NUM_THR];
   logic [CNT_W-1:0]           crossings [NUM_THR];
   logic [CNT_W-1:0]           above_hits [NUM_THR];

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * 10);
      $display("** waveform_feature_extractor: FAILED **");
      $finish;
   end

   function automatic void clear_wave();
      for (int j = 0; j < MAX_WIN; j++) history[j] = '0;
      count_in_wave = 0;
      wave_max      = 0;
      wave_min      = 0;
      best_sum      = 0;
      best_at       = 0;
      sum_total     = 0;
      for (int j = 0; j < NUM_THR; j++) begin
         hyst[j]       = HY_NEITHER;
         crossings[j]  = '0;
         above_hits[j] = '0;
      end
   endfunction

   // Advance the expected features by one accepted item; queue results on the last one
   function automatic void track_sample(input logic signed [SAMPLE_W-1:0] value,
                                        input logic last);
      int          len;
      int          sum;
      int          acc;
      int          t;
      logic        hi;
      logic        lo;
      feature_type f;
      len = (win_len == 0) ? 1 : ((win_len > MAX_WIN) ? MAX_WIN : win_len);
      for (int j = MAX_WIN - 1; j > 0; j--) history[j] = history[j-1];
      history[0] = value;
      sum = 0;
      for (int j = 0; j < len; j++) sum += history[j];

      // full window: peak, total and per-threshold hits
      if (count_in_wave + 1 >= len) begin
         if (sum > best_sum) begin
            best_sum = sum;
            best_at  = (count_in_wave < POS_MAX) ? count_in_wave : POS_MAX;
         end
         acc = sum_total + sum;
         if (acc > ACC_HI) acc = ACC_HI;
         if (acc < ACC_LO) acc = ACC_LO;
         sum_total = acc;
         for (int j = 0; j < NUM_THR; j++)
            if (sum > thr_level[j] && above_hits[j] != CNT_MAX) above_hits[j]++;
      end

      if (value > wave_max) wave_max = value;
      if (value < wave_min) wave_min = value;

      // hysteresis between +thr and -thr
      for (int j = 0; j < NUM_THR; j++) begin
         t  = thr_level[j];
         hi = (value > t);
         lo = (value < -t);
         case (hyst[j])
            HY_NEITHER: begin
               if (hi) hyst[j] = HY_HIGH;
               else if (lo) hyst[j] = HY_LOW;
            end
            HY_HIGH: begin
               if (lo) begin
                  if (crossings[j] != CNT_MAX) crossings[j]++;
                  hyst[j] = HY_LOW;
               end
            end
            default: begin
               if (hi) begin
                  if (crossings[j] != CNT_MAX) crossings[j]++;
                  hyst[j] = HY_HIGH;
               end
            end
         endcase
      end

      if (count_in_wave < IDX_SAT) count_in_wave++;

      if (last) begin
         for (int j = 0; j < NUM_THR; j++) begin
            f.thresh_index     = j[TIDX_W-1:0];
            f.crossing_count   = crossings[j];
            f.above_count      = above_hits[j];
            f.peak_sample      = wave_max[PEAK_W-1:0];
            f.trough_sample    = wave_min[SAMPLE_W-1:0];
            f.peak_window_sum  = best_sum[PWS_W-1:0];
            f.peak_position    = best_at[POS_W-1:0];
            f.window_sum_total = sum_total[ACC_W-1:0];
            f.run_last         = (j == NUM_THR - 1);
            pending_features.push_back(f);
         end
         clear_wave();
      end
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return SAMPLE_W'($urandom_range(0, 4095));
      if (r < 8) return SAMPLE_W'($urandom_range(0, 800) - 400);
      if (r == 8) return SAMPLE_W'(2047);
      return SAMPLE_W'(-2048);
   endfunction

   function automatic int random_window();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 0;
         1: return $urandom_range(MAX_WIN + 1, 63);
         2: return MAX_WIN;
         3: return 1;
         default: return $urandom_range(1, MAX_WIN);
      endcase
   endfunction

   function automatic int random_threshold();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 0;
      if (r == 2) return 65535;
      if (r < 7) return $urandom_range(0, 300);
      if (r == 7) return $urandom_range(2046, 2048);
      return $urandom_range(0, 65535);
   endfunction

   // Receiver: random stalls, plus a long hold when one is requested
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = pick_gap();
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, $signed(want),
                  $signed(got));
         mismatch_count++;
      end
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      feature_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_features.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual index %0d",
                     $time, rsp_bus.thresh_index);
            mismatch_count++;
         end else begin
            want = pending_features.pop_front();
            check_field("thresh_index", 32'(want.thresh_index),
                        32'(rsp_bus.thresh_index));
            check_field("crossing_count", 32'(want.crossing_count),
                        32'(rsp_bus.crossing_count));
            check_field("above_count", 32'(want.above_count),
                        32'(rsp_bus.above_count));
            check_field("peak_sample", 32'(want.peak_sample),
                        32'(rsp_bus.peak_sample));
            check_field("trough_sample", 32'(want.trough_sample),
                        32'(rsp_bus.trough_sample));
            check_field("peak_window_sum", 32'(want.peak_window_sum),
                        32'(rsp_bus.peak_window_sum));
            check_field("peak_position", 32'(want.peak_position),
                        32'(rsp_bus.peak_position));
            check_field("window_sum_total", 32'(want.window_sum_total),
                        32'(rsp_bus.window_sum_total));
            check_field("run_last", 32'(want.run_last), 32'(rsp_bus.run_last));
         end
      end
   end

   // Offer one item and wait until it is taken; valid stays high for the caller
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.sample       <= value;
      req_bus.final_sample <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track_sample(value, last);
   endtask

   task automatic send_wave(input wave_type wave, input bit close_wave);
      for (int i = 0; i < wave.size(); i++)
         send_sample(wave[i], close_wave && (i == wave.size() - 1));
   endtask

   function automatic wave_type random_wave(input int len);
      wave_type w;
      for (int i = 0; i < len; i++) w.push_back(random_sample());
      return w;
   endfunction

   // Drop valid, wait for every expected result, then let the pipeline drain
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_features.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; the enable stays high for a following write
   task automatic write_reg(input int idx, input int value);
      csr_write_en <= 1'b1;
      csr_index    <= idx[CSR_IDX_W-1:0];
      csr_wdata    <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      if (idx == REG_WINDOW_LENGTH)
         win_len = value & ((1 << LEN_CFG_W) - 1);
      else if (idx < REG_THRESHOLD_0 + NUM_THR)
         thr_level[idx - REG_THRESHOLD_0] = value & ((1 << THR_W) - 1);
   endtask

   task automatic apply_settings(input int len, input thr_set_type thr);
      settle();
      write_reg(REG_WINDOW_LENGTH, len);
      for (int j = 0; j < NUM_THR; j++) write_reg(REG_THRESHOLD_0 + j, thr[j]);
      csr_write_en <= 1'b0;
   endtask

   // Reset values: window of ten, all thresholds zero
   task automatic test_reset_values();
      send_wave('{2047, -2048, 0, -1, 1, 100, -100, 5, 7, 2047, 300, -5}, 1'b1);
      settle();
   endtask

   // Window lengths at and beyond the limits, thresholds at the edges of the samples
   task automatic test_window_extremes();
      apply_settings(1, '{0, 1, 2047, 2048, 65535});
      send_wave('{2047, -2047, -2048, 2047}, 1'b1);
      apply_settings(0, '{65535, 0, 1, 2047, 2048});
      send_wave('{-2048}, 1'b1);
      apply_settings(63, '{0, 0, 0, 0, 0});
      send_wave('{100, 200, 300}, 1'b1);
      apply_settings(MAX_WIN, '{1, 2, 3, 4, 5});
      send_wave('{1}, 1'b1);
      settle();
   endtask

   // Shorten the window in the middle of a waveform
   task automatic test_length_change_midwave();
      apply_settings(4, '{0, 10, 500, 1500, 4000});
      send_wave('{600, -20, 1500, 700, 900}, 1'b0);
      settle();
      write_reg(REG_WINDOW_LENGTH, 2);
      csr_write_en <= 1'b0;
      send_wave('{-700, 1200, 50}, 1'b1);
      settle();
   endtask

   // Indexes past the last threshold must change nothing
   task automatic test_unused_registers();
      settle();
      for (int idx = REG_THRESHOLD_0 + NUM_THR; idx < (1 << CSR_IDX_W); idx++)
         write_reg(idx, 16'h0001);
      csr_write_en <= 1'b0;
      send_wave('{40, -40, 2047}, 1'b1);
      settle();
   endtask

   // A stretch with no idling on either side
   task automatic test_back_to_back();
      settle();
      gaps_on = 1'b0;
      for (int k = 0; k < 3; k++) send_wave(random_wave(10), 1'b1);
      settle();
      gaps_on = 1'b1;
   endtask

   // Hold the receiver off for a long time while short waveforms keep coming
   task automatic test_output_pressure();
      apply_settings(2, '{0, 50, 200, 1000, 3000});
      rsp_hold_cycles = HOLD_CYCLES;
      for (int k = 0; k < 8; k++) send_wave(random_wave(4), 1'b1);
      settle();
   endtask

   // Random waveforms under random settings
   task automatic test_random_waveforms();
      thr_set_type thr;
      int          sent;
      int          len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            for (int j = 0; j < NUM_THR; j++) thr[j] = random_threshold();
            apply_settings(random_window(), thr);
         end
         len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(20, 48);
         send_wave(random_wave(len), 1'b1);
         sent += len;
      end
      settle();
   endtask

   initial begin
      reset                <= 1'b1;
      csr_write_en         <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.sample       <= '0;
      req_bus.final_sample <= 1'b0;
      win_len = LEN_RESET;
      for (int j = 0; j < NUM_THR; j++) thr_level[j] = 0;
      clear_wave();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_window_extremes();
      test_length_change_midwave();
      test_unused_registers();
      test_back_to_back();
      test_output_pressure();
      test_random_waveforms();

      settle();
      if (mismatch_count == 0) begin
         $display("** waveform_feature_extractor: PASSED **");
      end else begin
         $display("** waveform_feature_extractor: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/wfe_pkg.sv
rtl/wfe_if.sv
rtl/wfe_thr_lane.sv
rtl/waveform_feature_extractor.sv
sim/tb_top.sv
